/* rtl/sct_pkg.sv */
package sct_pkg;

	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [3:0] FINAL_INDEX = 4'd8;

	localparam logic [10:0] SETPOINT_RESET = 11'd800;
	localparam logic [9:0] HYST_RESET = 10'd50;
	localparam logic signed [10:0] OFFSET_RESET = -11'sd300;

	localparam logic signed [20:0] MEAS_MAX = 21'sd32767;
	localparam logic signed [20:0] MEAS_MIN = -21'sd32768;

	typedef enum logic [1:0] {
		FAULT_NONE   = 2'd0,
		FAULT_ABSENT = 2'd1,
		FAULT_CRC    = 2'd2,
		FAULT_RSVD   = 2'd3
	} fault_t;

	typedef enum logic [1:0] {
		REG_SETPOINT = 2'd0,
		REG_HYST     = 2'd1,
		REG_RAPID    = 2'd2,
		REG_OFFSET   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [10:0] setpoint;
		logic [9:0] hyst;
		logic rapid;
		logic signed [10:0] offset;
	} sct_cfg_t;

	// A finished frame or a no-presence event, handed from the frame stage to control.
	typedef struct packed {
		logic valid;
		logic absent;
		logic crc_ok;
		logic signed [15:0] raw;
	} sct_evt_t;

	// Reflected CRC-8 over one byte, least significant bit first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] crc;
		logic mix;
		crc = crc_in;
		for (int k = 0; k < 8; k++) begin
			mix = crc[0] ^ b[k];
			crc = {1'b0, crc[7:1]};
			if (mix) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

endpackage

/* rtl/scratchpad_crc_thermostat.sv */
// An accepted request is registered in the frame stage and then in the control stage,
// whose registers drive the outputs.
// Throughput: one scratchpad byte or no-presence event per cycle while results are taken;
// a result held back by the receiver stops further requests, once the frame stage is full, until it is taken.
// The ninth byte of a frame and each no-presence event give one result each.
// Reset (arst_n low) clears the frame position, the CRC, the relay and both pipeline valids.
module scratchpad_crc_thermostat
	import sct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write_en,
	input  logic [1:0] cfg_index,
	input  logic [10:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic command,
	input  logic [7:0] data_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic cooler_on,
	output logic [1:0] fault_code,
	output logic signed [15:0] measured_centideg
);

	sct_cfg_t cfg_q;
	sct_evt_t evt;
	logic advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint <= SETPOINT_RESET;
			cfg_q.hyst <= HYST_RESET;
			cfg_q.rapid <= 1'b0;
			cfg_q.offset <= OFFSET_RESET;
		end else if (cfg_write_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SETPOINT: cfg_q.setpoint <= cfg_data;
				REG_HYST:     cfg_q.hyst <= cfg_data[9:0];
				REG_RAPID:    cfg_q.rapid <= cfg_data[0];
				REG_OFFSET:   cfg_q.offset <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	sct_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.data_byte (data_byte),
		.advance   (advance),
		.evt       (evt)
	);

	sct_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.evt               (evt),
		.cfg               (cfg_q),
		.advance           (advance),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.cooler_on         (cooler_on),
		.fault_code        (fault_code),
		.measured_centideg (measured_centideg)
	);

endmodule

/* rtl/sct_frame.sv */
module sct_frame
	import sct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic command,
	input  logic [7:0] data_byte,
	input  logic advance,
	output sct_evt_t evt
);

	logic valid_s1;
	logic command_s1;
	logic [7:0] byte_s1;
	logic [7:0] crc_q;
	logic [3:0] idx_q;
	logic [7:0] raw_lo_q;
	logic [7:0] raw_hi_q;
	logic fire;
	logic is_final;

	assign in_ready = !valid_s1 || advance;
	assign fire = valid_s1 && advance;
	assign is_final = idx_q >= FINAL_INDEX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= command;
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
			idx_q <= '0;
			raw_lo_q <= '0;
			raw_hi_q <= '0;
		end else if (fire) begin
			if (command_s1 || is_final) begin
				crc_q <= '0;
				idx_q <= '0;
			end else begin
				crc_q <= crc8_byte(crc_q, byte_s1);
				idx_q <= idx_q + 4'd1;
				if (idx_q == 4'd0) begin
					raw_lo_q <= byte_s1;
				end
				if (idx_q == 4'd1) begin
					raw_hi_q <= byte_s1;
				end
			end
		end
	end

	always_comb begin
		evt.valid = valid_s1 && (command_s1 || is_final);
		evt.absent = command_s1;
		evt.crc_ok = crc_q == byte_s1;
		evt.raw = $signed({raw_hi_q, raw_lo_q});
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= FINAL_INDEX)
		else $error("byte index past the final byte");

	a_idx_zero_crc: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q == 4'd0 |-> crc_q == 8'd0)
		else $error("CRC not cleared at frame start");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(idx_q))
		else $error("stalled request lost in frame stage");

endmodule

/* rtl/sct_ctrl.sv */
module sct_ctrl
	import sct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sct_evt_t evt,
	input  sct_cfg_t cfg,
	output logic advance,
	output logic out_valid,
	input  logic out_ready,
	output logic cooler_on,
	output logic [1:0] fault_code,
	output logic signed [15:0] measured_centideg
);

	logic relay_q;
	logic valid_s2;
	logic relay_s2;
	fault_t fault_s2;
	logic signed [15:0] meas_s2;

	logic signed [20:0] prod;
	logic signed [20:0] quot;
	logic signed [15:0] meas_c;
	logic signed [17:0] meas_x;
	logic signed [17:0] tgt;
	logic signed [17:0] band_hi;
	logic signed [17:0] band_lo;
	logic relay_c;
	fault_t fault_c;
	logic signed [15:0] meas_out_c;

	assign advance = !valid_s2 || out_ready;

	always_comb begin
		prod = $signed({{5{evt.raw[15]}}, evt.raw}) * 21'sd25;
		// Round towards zero before the arithmetic shift.
		quot = (prod + (prod[20] ? 21'sd3 : 21'sd0)) >>> 2;
		if (quot > MEAS_MAX) begin
			meas_c = 16'sh7FFF;
		end else if (quot < MEAS_MIN) begin
			meas_c = -16'sh8000;
		end else begin
			meas_c = quot[15:0];
		end
		meas_x = {{2{meas_c[15]}}, meas_c};
		tgt = $signed({7'd0, cfg.setpoint});
		if (cfg.rapid) begin
			tgt = tgt + $signed({{7{cfg.offset[10]}}, cfg.offset});
		end
		band_hi = tgt + $signed({8'd0, cfg.hyst});
		band_lo = tgt - $signed({8'd0, cfg.hyst});

		relay_c = relay_q;
		fault_c = FAULT_NONE;
		meas_out_c = meas_c;
		if (evt.absent) begin
			relay_c = 1'b0;
			fault_c = FAULT_ABSENT;
			meas_out_c = '0;
		end else if (!evt.crc_ok) begin
			relay_c = 1'b0;
			fault_c = FAULT_CRC;
			meas_out_c = '0;
		end else if (meas_x >= band_hi) begin
			relay_c = 1'b1;
		end else if (meas_x <= band_lo) begin
			relay_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			relay_q <= 1'b0;
		end else if (advance) begin
			valid_s2 <= evt.valid;
			if (evt.valid) begin
				relay_q <= relay_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && evt.valid) begin
			relay_s2 <= relay_c;
			fault_s2 <= fault_c;
			meas_s2 <= meas_out_c;
		end
	end

	assign out_valid = valid_s2;
	assign cooler_on = relay_s2;
	assign fault_code = fault_s2;
	assign measured_centideg = meas_s2;

	a_fault_relay_off: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && fault_s2 != FAULT_NONE |-> !relay_s2 && meas_s2 == 16'sd0)
		else $error("faulted reading with relay on or a temperature");

	a_relay_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> relay_s2 == relay_q)
		else $error("delivered relay state differs from held state");

	a_fault_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> fault_s2 != FAULT_RSVD)
		else $error("reserved fault code delivered");

endmodule

/* verif/scratchpad_crc_thermostat_tb.sv */
`timescale 1ns / 1ps

module scratchpad_crc_thermostat_tb;
	import sct_pkg::*;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_ABSENT = 1'b1;
	localparam int N_DIRECTED = 31;
	localparam int RANDOM_ITEMS = 1020;
	localparam int FRAMES_PER_PHASE = 12;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int LONG_HOLD_AFTER = 35;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_CRC_OK,
		ROW_CRC_BAD,
		ROW_ABSENT
	} row_kind_t;

	typedef struct packed {
		logic relay;
		fault_t fault;
		logic signed [15:0] meas;
	} reading_t;

	typedef struct packed {
		row_kind_t kind;
		logic [7:0] data;
		logic typed;
		reading_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write_en;
	logic [1:0] cfg_index;
	logic [10:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic command;
	logic [7:0] data_byte;
	logic out_valid;
	logic out_ready;
	logic cooler_on;
	logic [1:0] fault_code;
	logic signed [15:0] measured_centideg;

	logic typed_valid;
	reading_t typed_reading;

	reading_t pending_readings[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int sent_items = 0;
	bit tx_eager = 1'b0;
	bit rx_eager = 1'b0;

	logic [10:0] m_sp;
	logic [9:0] m_hy;
	logic m_rapid;
	logic signed [10:0] m_off;
	logic [7:0] m_crc;
	logic [3:0] m_idx;
	logic [7:0] m_lo;
	logic [7:0] m_hi;
	logic m_relay;

	scratchpad_crc_thermostat dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cooler_on(cooler_on),
		.fault_code(fault_code),
		.measured_centideg(measured_centideg)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] din);
		logic [7:0] c;
		logic [7:0] d;
		c = acc;
		d = din;
		repeat (8) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

	function automatic int idle_len(input bit eager);
		int r;
		if (eager) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic stim_row_t plain_row(input row_kind_t k, input logic [7:0] d);
		stim_row_t s;
		s = '0;
		s.kind = k;
		s.data = d;
		return s;
	endfunction

	function automatic stim_row_t checked_row(input row_kind_t k, input logic [7:0] d,
			input logic rl, input fault_t f, input logic [15:0] m);
		stim_row_t s;
		s = '0;
		s.kind = k;
		s.data = d;
		s.typed = 1'b1;
		s.want.relay = rl;
		s.want.fault = f;
		s.want.meas = m;
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic thermostat_step(input logic cmd, input logic [7:0] b,
			output logic hit, output reading_t res);
		int raw;
		int meas;
		int target;
		int hy;
		hit = 1'b0;
		res = '0;
		if (cmd == CMD_ABSENT) begin
			m_relay = 1'b0;
			m_crc = '0;
			m_idx = '0;
			hit = 1'b1;
			res.fault = FAULT_ABSENT;
		end else if (m_idx < FINAL_INDEX) begin
			m_crc = crc_next(m_crc, b);
			if (m_idx == 4'd0) begin
				m_lo = b;
			end else if (m_idx == 4'd1) begin
				m_hi = b;
			end
			m_idx = m_idx + 4'd1;
		end else begin
			hit = 1'b1;
			if (m_crc != b) begin
				m_relay = 1'b0;
				res.fault = FAULT_CRC;
			end else begin
				raw = $signed({m_hi, m_lo});
				meas = (raw * 25) / 4;
				if (meas > 32767) begin
					meas = 32767;
				end
				if (meas < -32768) begin
					meas = -32768;
				end
				target = int'(m_sp);
				if (m_rapid) begin
					target = target + int'(m_off);
				end
				hy = int'(m_hy);
				if (meas >= target + hy) begin
					m_relay = 1'b1;
				end else if (meas <= target - hy) begin
					m_relay = 1'b0;
				end
				res.fault = FAULT_NONE;
				res.meas = meas[15:0];
			end
			res.relay = m_relay;
			m_crc = '0;
			m_idx = '0;
		end
	endtask

	task automatic send_item(input logic cmd, input logic [7:0] d, input logic typed,
			input reading_t want);
		int g;
		g = idle_len(tx_eager);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		data_byte <= d;
		typed_valid <= typed;
		typed_reading <= want;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_items++;
	endtask

	task automatic send_frame();
		logic [7:0] fb [0:8];
		logic [15:0] raw;
		logic [7:0] crc;
		int r;
		int n_keep;
		int k;
		r = $urandom_range(0, 19);
		if (r < 14) begin
			raw = 16'($urandom_range(0, 1000)) - 16'd250;
		end else if (r < 17) begin
			raw = 16'($urandom);
		end else begin
			case ($urandom_range(0, 5))
				0: raw = 16'h7FFF;
				1: raw = 16'h8000;
				2: raw = 16'h147A;
				3: raw = 16'h147B;
				4: raw = 16'hEB85;
				default: raw = 16'hFFFF;
			endcase
		end
		fb[0] = raw[7:0];
		fb[1] = raw[15:8];
		for (k = 2; k < 8; k++) begin
			fb[k] = 8'($urandom_range(0, 255));
		end
		crc = '0;
		for (k = 0; k < 8; k++) begin
			crc = crc_next(crc, fb[k]);
		end
		r = $urandom_range(0, 99);
		if (r < 6) begin
			send_item(CMD_ABSENT, 8'($urandom_range(0, 255)), 1'b0, '0);
		end else if (r < 12) begin
			n_keep = $urandom_range(0, 8);
			for (k = 0; k < n_keep; k++) begin
				send_item(CMD_BYTE, fb[k], 1'b0, '0);
			end
			send_item(CMD_ABSENT, 8'($urandom_range(0, 255)), 1'b0, '0);
		end else begin
			fb[8] = (r < 20) ? (crc ^ (8'h01 << $urandom_range(0, 7))) : crc;
			for (k = 0; k < 9; k++) begin
				send_item(CMD_BYTE, fb[k], 1'b0, '0);
			end
		end
	endtask

	task automatic write_config(input int sp, input int hy, input int rap, input int off);
		cfg_write_en <= 1'b1;
		cfg_index <= REG_SETPOINT;
		cfg_data <= 11'(sp);
		@(posedge clk);
		cfg_index <= REG_HYST;
		cfg_data <= {1'($urandom_range(0, 1)), 10'(hy)};
		@(posedge clk);
		cfg_index <= REG_RAPID;
		cfg_data <= {10'($urandom), 1'(rap)};
		@(posedge clk);
		cfg_index <= REG_OFFSET;
		cfg_data <= 11'(off);
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	always @(posedge clk) begin
		reading_t want;
		reading_t pred;
		logic hit;
		if (arst_n) begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_SETPOINT: m_sp = cfg_data;
					REG_HYST: m_hy = cfg_data[9:0];
					REG_RAPID: m_rapid = cfg_data[0];
					REG_OFFSET: m_off = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_readings.size() == 0) begin
					report_mismatch($sformatf("unexpected result: cooler %0b fault %0d measured %0d",
						cooler_on, fault_code, measured_centideg));
				end else begin
					want = pending_readings.pop_front();
					if (cooler_on !== want.relay) begin
						report_mismatch($sformatf("cooler_on: got %0b, want %0b",
							cooler_on, want.relay));
					end
					if (fault_code !== want.fault) begin
						report_mismatch($sformatf("fault_code: got %0d, want %0d",
							fault_code, want.fault));
					end
					if (measured_centideg !== want.meas) begin
						report_mismatch($sformatf("measured_centideg: got %0d, want %0d",
							measured_centideg, want.meas));
					end
				end
			end
			if (in_valid && in_ready) begin
				thermostat_step(command, data_byte, hit, pred);
				if (hit) begin
					pending_readings.push_back(typed_valid ? typed_reading : pred);
				end
			end
			if ((out_valid && out_ready) || (in_valid && in_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	initial begin
		int g;
		int rx_count;
		rx_count = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_count == LONG_HOLD_AFTER) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else begin
				g = idle_len(rx_eager);
				if (g > 0) begin
					out_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			rx_count++;
			if (rx_count % 40 == 0) begin
				rx_eager = ($urandom_range(0, 2) == 0);
			end
		end
	end

	initial begin
		stim_row_t directed_rows [N_DIRECTED];
		stim_row_t r;
		logic [7:0] tx_crc;
		logic [7:0] d;
		logic cmd;
		int i;
		int p;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = REG_SETPOINT;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_BYTE;
		data_byte = '0;
		typed_valid = 1'b0;
		typed_reading = '0;
		m_sp = SETPOINT_RESET;
		m_hy = HYST_RESET;
		m_rapid = 1'b0;
		m_off = OFFSET_RESET;
		m_crc = '0;
		m_idx = '0;
		m_lo = '0;
		m_hi = '0;
		m_relay = 1'b0;
		directed_rows = '{
			checked_row(ROW_ABSENT, 8'h5A, 1'b0, FAULT_ABSENT, 16'h0000),
			plain_row(ROW_BYTE, 8'hFF), plain_row(ROW_BYTE, 8'h7F),
			plain_row(ROW_BYTE, 8'h00), plain_row(ROW_BYTE, 8'hFF),
			plain_row(ROW_BYTE, 8'h55), plain_row(ROW_BYTE, 8'hAA),
			plain_row(ROW_BYTE, 8'h01), plain_row(ROW_BYTE, 8'h80),
			checked_row(ROW_CRC_OK, 8'h00, 1'b1, FAULT_NONE, 16'h7FFF),
			plain_row(ROW_BYTE, 8'h90), plain_row(ROW_BYTE, 8'h01),
			plain_row(ROW_BYTE, 8'h4B), plain_row(ROW_BYTE, 8'h46),
			plain_row(ROW_BYTE, 8'h7F), plain_row(ROW_BYTE, 8'hFF),
			plain_row(ROW_BYTE, 8'h0C), plain_row(ROW_BYTE, 8'h10),
			checked_row(ROW_CRC_BAD, 8'h00, 1'b0, FAULT_CRC, 16'h0000),
			plain_row(ROW_BYTE, 8'h00), plain_row(ROW_BYTE, 8'h80),
			plain_row(ROW_BYTE, 8'hFF), plain_row(ROW_BYTE, 8'h00),
			plain_row(ROW_BYTE, 8'hC3), plain_row(ROW_BYTE, 8'h3C),
			plain_row(ROW_BYTE, 8'h10), plain_row(ROW_BYTE, 8'h08),
			checked_row(ROW_CRC_OK, 8'h00, 1'b0, FAULT_NONE, 16'h8000),
			plain_row(ROW_BYTE, 8'h12), plain_row(ROW_BYTE, 8'h34),
			checked_row(ROW_ABSENT, 8'hA5, 1'b0, FAULT_ABSENT, 16'h0000)
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_crc = '0;
		for (i = 0; i < N_DIRECTED; i++) begin
			r = directed_rows[i];
			cmd = CMD_BYTE;
			d = r.data;
			case (r.kind)
				ROW_BYTE: tx_crc = crc_next(tx_crc, r.data);
				ROW_CRC_OK: begin
					d = tx_crc;
					tx_crc = '0;
				end
				ROW_CRC_BAD: begin
					d = ~tx_crc;
					tx_crc = '0;
				end
				default: begin
					cmd = CMD_ABSENT;
					tx_crc = '0;
				end
			endcase
			send_item(cmd, d, r.typed, r.want);
		end

		p = 0;
		while (sent_items < N_DIRECTED + RANDOM_ITEMS) begin
			if (p > 0) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_readings.size() != 0) @(posedge clk);
				repeat (4) @(posedge clk);
				case (p)
					1: write_config(0, 0, 0, 0);
					2: write_config(2000, 1000, 1, -1000);
					3: write_config(2047, 1023, 1, -1024);
					4: write_config(0, 1023, 1, 1023);
					default: write_config($urandom_range(0, 2047),
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
							: $urandom_range(0, 120),
						$urandom_range(0, 1), $urandom_range(0, 2047));
				endcase
			end
			tx_eager = ($urandom_range(0, 2) == 0);
			repeat (FRAMES_PER_PHASE) send_frame();
			p++;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_readings.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
